FILE: hw/rtl/qcms_pkg.sv
`timescale 1ns / 1ps

package qcms_pkg;

	// Action codes carried by an input transaction.
	typedef enum logic [2:0] {
		ACT_EDGE_A = 3'd0,
		ACT_EDGE_B = 3'd1,
		ACT_SAMPLE = 3'd2,
		ACT_LOAD   = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	typedef struct packed {
		action_t            action;
		logic               a_level;
		logic               b_level;
		logic        [31:0] timer_value;
		logic signed [31:0] load_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] position_count;
		logic        [31:0] timer_delta;
		logic signed [31:0] count_delta;
		logic               captured;
		logic               sample_pending;
	} out_item_t;

endpackage

FILE: hw/rtl/qcms_update.sv
`timescale 1ns / 1ps

// Next-state and result logic for one transaction. Purely combinational.
module qcms_update import qcms_pkg::*; #(
	parameter int COUNT_BITS = 32,
	parameter int TIMER_BITS = 32
) (
	input  in_item_t              item,
	input  logic [COUNT_BITS-1:0] position,
	input  logic                  pending,
	input  logic [TIMER_BITS-1:0] prev_timer,
	input  logic [COUNT_BITS-1:0] prev_count,
	input  logic [TIMER_BITS-1:0] last_timer_delta,
	input  logic [COUNT_BITS-1:0] last_count_delta,
	output logic [COUNT_BITS-1:0] position_next,
	output logic                  pending_next,
	output logic [TIMER_BITS-1:0] prev_timer_next,
	output logic [COUNT_BITS-1:0] prev_count_next,
	output logic [TIMER_BITS-1:0] last_timer_delta_next,
	output logic [COUNT_BITS-1:0] last_count_delta_next,
	output out_item_t             result
);

	logic [63:0]           load_ext;
	logic [63:0]           tval_ext;
	logic [COUNT_BITS-1:0] edge_pos;
	logic                  down;
	logic                  cap;
	logic [63:0]           pos_out_ext;
	logic [63:0]           td_out_ext;
	logic [63:0]           cd_out_ext;

	assign load_ext = 64'(item.load_value);
	assign tval_ext = 64'(item.timer_value);

	// An edge on B counts in the opposite sense of an edge on A.
	assign down = (item.action == ACT_EDGE_A) ? (item.a_level ^ item.b_level)
	                                          : ~(item.a_level ^ item.b_level);
	assign edge_pos = down ? (position - COUNT_BITS'(1)) : (position + COUNT_BITS'(1));

	always_comb begin
		position_next         = position;
		pending_next          = pending;
		prev_timer_next       = prev_timer;
		prev_count_next       = prev_count;
		last_timer_delta_next = last_timer_delta;
		last_count_delta_next = last_count_delta;
		cap                   = 1'b0;
		unique case (item.action)
			ACT_EDGE_A, ACT_EDGE_B: begin
				position_next = edge_pos;
				if (pending) begin
					last_timer_delta_next = tval_ext[TIMER_BITS-1:0] - prev_timer;
					prev_timer_next       = tval_ext[TIMER_BITS-1:0];
					last_count_delta_next = edge_pos - prev_count;
					prev_count_next       = edge_pos;
					pending_next          = 1'b0;
					cap                   = 1'b1;
				end
			end
			ACT_SAMPLE: begin
				pending_next = 1'b1;
			end
			ACT_LOAD: begin
				position_next = load_ext[COUNT_BITS-1:0];
			end
			ACT_CLEAR: begin
				position_next = '0;
			end
			default: begin
			end
		endcase
	end

	assign pos_out_ext = 64'(signed'(position_next));
	assign td_out_ext  = 64'(last_timer_delta_next);
	assign cd_out_ext  = 64'(signed'(last_count_delta_next));

	always_comb begin
		result.position_count = pos_out_ext[31:0];
		result.timer_delta    = td_out_ext[31:0];
		result.count_delta    = cd_out_ext[31:0];
		result.captured       = cap;
		result.sample_pending = pending_next;
	end

endmodule

FILE: hw/rtl/quadrature_count_mt_speed_capture.sv
`timescale 1ns / 1ps

// Quadrature position counter with M/T speed capture. Each input transaction
// is an encoder edge on A or B, a sample request, a count load or a clear,
// and each one yields exactly one result transaction carrying the position
// after it, the timer and count deltas of the most recent capture, a flag
// that this transaction performed a capture and the pending-sample flag.
// The block accepts one transaction per clock cycle while the output is not
// stalled, and each result passes through the input register and then the
// result register. The rate is set by the state update loop, where the
// counter and capture registers feed back into the update logic. COUNT_BITS
// and TIMER_BITS (8 to 64) set the counter and timer
// widths; the ports stay 32 bits, wider internal values report their low
// 32 bits and narrower counts are sign-extended.
module quadrature_count_mt_speed_capture import qcms_pkg::*; #(
	parameter int COUNT_BITS = 32,
	parameter int TIMER_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	// Input register.
	logic      valid_s1;
	in_item_t  item_s1;

	// Result register.
	logic      valid_s2;
	out_item_t result_s2;

	// Counter and capture state.
	logic [COUNT_BITS-1:0] position_q;
	logic                  pending_q;
	logic [TIMER_BITS-1:0] prev_timer_q;
	logic [COUNT_BITS-1:0] prev_count_q;
	logic [TIMER_BITS-1:0] last_timer_delta_q;
	logic [COUNT_BITS-1:0] last_count_delta_q;

	logic [COUNT_BITS-1:0] position_next;
	logic                  pending_next;
	logic [TIMER_BITS-1:0] prev_timer_next;
	logic [COUNT_BITS-1:0] prev_count_next;
	logic [TIMER_BITS-1:0] last_timer_delta_next;
	logic [COUNT_BITS-1:0] last_count_delta_next;
	out_item_t             result_next;

	logic advance;

	// The held transaction moves on whenever the result register is empty
	// or its transaction is being taken in this cycle; a waiting result that
	// is not taken holds the input register full and stalls the input side.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	qcms_update #(
		.COUNT_BITS (COUNT_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_update (
		.item                  (item_s1),
		.position              (position_q),
		.pending               (pending_q),
		.prev_timer            (prev_timer_q),
		.prev_count            (prev_count_q),
		.last_timer_delta      (last_timer_delta_q),
		.last_count_delta      (last_count_delta_q),
		.position_next         (position_next),
		.pending_next          (pending_next),
		.prev_timer_next       (prev_timer_next),
		.prev_count_next       (prev_count_next),
		.last_timer_delta_next (last_timer_delta_next),
		.last_count_delta_next (last_count_delta_next),
		.result                (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// State commits only when the transaction in the input register is
	// handed to the result register, so every transaction updates it once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q         <= '0;
			pending_q          <= 1'b0;
			prev_timer_q       <= '0;
			prev_count_q       <= '0;
			last_timer_delta_q <= '0;
			last_count_delta_q <= '0;
		end else if (advance) begin
			position_q         <= position_next;
			pending_q          <= pending_next;
			prev_timer_q       <= prev_timer_next;
			prev_count_q       <= prev_count_next;
			last_timer_delta_q <= last_timer_delta_next;
			last_count_delta_q <= last_count_delta_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule
